>>> rtl/core/lspq_pkg.sv
// ----------------------------------------------------------------------------
// Linear scan priority queue package
// Request and response types, status and command codes, sequencer states
// and default sizes shared by the queue, its checker and its testbench.
// ----------------------------------------------------------------------------
package lspq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int PRIO_BITS_DEF = 8;
	localparam int DATA_BITS_DEF = 16;

	localparam int PRIO_FIELD_W = 8;
	localparam int DATA_FIELD_W = 16;
	localparam int OCC_FIELD_W  = 5;

	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_EXTRACT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_EXTRACTED = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic [PRIO_FIELD_W-1:0] priority_req;
		logic [DATA_FIELD_W-1:0] payload;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [PRIO_FIELD_W-1:0] out_priority;
		logic [DATA_FIELD_W-1:0] out_payload;
		logic [OCC_FIELD_W-1:0]  occupancy;
	} rsp_t;

endpackage

>>> rtl/core/lspq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lspq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/linear_scan_priority_queue.sv
// ----------------------------------------------------------------------------
// Linear scan priority queue
// A bounded queue of priority and data pairs kept compact in arrival order.
//
// A request on the req channel either inserts an entry at the end of the
// store or extracts the entry of highest priority, the earliest one among
// equal priorities. Every request yields exactly one response on the rsp
// channel with a status, the extracted entry and the occupancy afterward.
// One request is worked on at a time and req_stall is high meanwhile.
// An insert, full or not, and an extract from an empty store go from
// dispatch straight to the response state. An extract of n stored entries
// scans all n and then, if t later entries follow the winner, shifts them
// down before the response: the scan reads one entry per cycle through
// the single read port of the store, and the shift copies one per cycle.
// The response sits in an output register; while rsp_stall is high it
// holds, and the next request is accepted but waits before its response.
// Reset empties the queue; the store itself is not cleared.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue #(
	parameter int DEPTH     = lspq_pkg::DEPTH_DEF,
	parameter int PRIO_BITS = lspq_pkg::PRIO_BITS_DEF,
	parameter int DATA_BITS = lspq_pkg::DATA_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lspq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lspq_pkg::rsp_t rsp
);

	import lspq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = PRIO_BITS + DATA_BITS;

	state_t               state_q;
	state_t               state_d;
	req_t                 req_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     cmp_idx_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [IDX_W-1:0]     sh_idx_q;
	logic [PRIO_BITS-1:0] best_prio_q;
	logic [DATA_BITS-1:0] best_data_q;
	status_t              res_status_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ENT_W-1:0]     ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	logic [ENT_W-1:0]     ram_rdata;

	logic                 req_acc;
	logic                 full;
	logic                 empty;
	logic [PRIO_BITS-1:0] rd_prio;
	logic [DATA_BITS-1:0] rd_data;
	logic [CNT_W-1:0]     cmp_next;
	logic                 scan_last;
	logic                 take;
	logic [IDX_W-1:0]     win_idx;
	logic [CNT_W-1:0]     win_next;
	logic                 has_tail;
	logic [CNT_W-1:0]     sh_next2;
	logic                 sh_more;
	logic                 rsp_load;
	logic                 dec_count;

	lspq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_acc   = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign rd_prio   = ram_rdata[ENT_W-1 -: PRIO_BITS];
	assign rd_data   = ram_rdata[DATA_BITS-1:0];
	assign cmp_next  = CNT_W'(cmp_idx_q) + CNT_W'(1);
	assign scan_last = (cmp_next == count_q);
	assign take      = (cmp_idx_q == '0) || (rd_prio > best_prio_q);
	assign win_idx   = take ? cmp_idx_q : best_idx_q;
	assign win_next  = CNT_W'(win_idx) + CNT_W'(1);
	assign has_tail  = (win_next < count_q);
	assign sh_next2  = CNT_W'(sh_idx_q) + CNT_W'(2);
	assign sh_more   = (sh_next2 < count_q);
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);
	assign dec_count = ((state_q == S_SCAN) && scan_last && !has_tail) ||
		((state_q == S_SHIFT) && !sh_more);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (req_q.cmd == CMD_EXTRACT && !empty) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = has_tail ? S_SHIFT : S_RESP;
				end
			end
			S_SHIFT: begin
				if (!sh_more) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = (state_q != S_IDLE);
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(count_q);
		ram_wdata = {PRIO_BITS'(req_q.priority_req), DATA_BITS'(req_q.payload)};
		ram_raddr = '0;
		case (state_q)
			S_DISPATCH: begin
				ram_we = (req_q.cmd == CMD_INSERT) && !full;
			end
			S_SCAN: begin
				ram_raddr = scan_last ? IDX_W'(win_next) : IDX_W'(cmp_next);
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = sh_idx_q;
				ram_wdata = ram_rdata;
				ram_raddr = IDX_W'(sh_next2);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DISPATCH && req_q.cmd == CMD_INSERT && !full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (dec_count) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		case (state_q)
			S_DISPATCH: begin
				cmp_idx_q <= '0;
				if (req_q.cmd == CMD_INSERT) begin
					res_status_q <= full ? ST_FULL : ST_INSERTED;
				end else begin
					res_status_q <= empty ? ST_EMPTY : ST_EXTRACTED;
				end
			end
			S_SCAN: begin
				if (take) begin
					best_idx_q  <= cmp_idx_q;
					best_prio_q <= rd_prio;
					best_data_q <= rd_data;
				end
				cmp_idx_q <= IDX_W'(cmp_next);
				sh_idx_q  <= win_idx;
			end
			S_SHIFT: begin
				sh_idx_q <= sh_idx_q + IDX_W'(1);
			end
			default: begin
				cmp_idx_q <= cmp_idx_q;
			end
		endcase
		if (rsp_load) begin
			rsp_q.status <= res_status_q;
			if (res_status_q == ST_EXTRACTED) begin
				rsp_q.out_priority <= PRIO_FIELD_W'(best_prio_q);
				rsp_q.out_payload  <= DATA_FIELD_W'(best_data_q);
			end else begin
				rsp_q.out_priority <= '0;
				rsp_q.out_payload  <= '0;
			end
			rsp_q.occupancy <= OCC_FIELD_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Entry count exceeds the store depth.");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_DISPATCH || state_q == S_SHIFT))
		else $error("Store written outside insert or compaction.");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && res_status_q == ST_EMPTY) |-> (count_q == '0))
		else $error("Empty status reported with entries stored.");

	a_count_dec: assert property (@(posedge clk) disable iff (!arst_n)
		dec_count |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("Extract did not remove exactly one entry.");

endmodule

>>> verif/linear_scan_priority_queue_checker.sv
// ----------------------------------------------------------------------------
// Linear scan priority queue checker
// Watches both channels of the queue and keeps its own copy of the stored
// entries. Every accepted request is worked through that copy, the response
// it must give is kept in order, and every accepted response is compared
// field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  lspq_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  lspq_pkg::rsp_t rsp,
	output int             mismatches,
	output int             outstanding
);

	import lspq_pkg::*;

	localparam int SLOTS = DEPTH_DEF;

	logic [PRIO_FIELD_W-1:0] held_prio [SLOTS];
	logic [DATA_FIELD_W-1:0] held_word [SLOTS];
	int                      held_count;
	rsp_t                    owed_replies [$];

	// Applies one request to the held entries and returns the response it earns.
	function automatic rsp_t serve(input req_t r);
		rsp_t o;
		int   best_at;
		o = '0;
		if (r.cmd == CMD_INSERT) begin
			if (held_count >= SLOTS) begin
				o.status = ST_FULL;
			end else begin
				held_prio[held_count] = r.priority_req;
				held_word[held_count] = r.payload;
				held_count++;
				o.status = ST_INSERTED;
			end
		end else if (held_count == 0) begin
			o.status = ST_EMPTY;
		end else begin
			best_at = 0;
			for (int k = 1; k < held_count; k++) begin
				if (held_prio[k] > held_prio[best_at])
					best_at = k;
			end
			o.status       = ST_EXTRACTED;
			o.out_priority = held_prio[best_at];
			o.out_payload  = held_word[best_at];
			for (int k = best_at; k + 1 < held_count; k++) begin
				held_prio[k] = held_prio[k + 1];
				held_word[k] = held_word[k + 1];
			end
			held_count--;
		end
		o.occupancy = OCC_FIELD_W'(held_count);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   fresh;
		if (!arst_n) begin
			held_count = 0;
			owed_replies.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			fresh = 0;
			if (rsp_valid && !rsp_stall) begin
				if (owed_replies.size() == 0) begin
					$display("%0t: response with none owed: expected none, actual %h",
						$time, rsp);
					fresh = 1;
				end else begin
					want = owed_replies.pop_front();
					if (rsp.status !== want.status)
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, rsp.status);
					if (rsp.out_priority !== want.out_priority)
						$display("%0t: out_priority expected %0d, actual %0d",
							$time, want.out_priority, rsp.out_priority);
					if (rsp.out_payload !== want.out_payload)
						$display("%0t: out_payload expected %h, actual %h",
							$time, want.out_payload, rsp.out_payload);
					if (rsp.occupancy !== want.occupancy)
						$display("%0t: occupancy expected %0d, actual %0d",
							$time, want.occupancy, rsp.occupancy);
					if (rsp !== want)
						fresh = 1;
				end
			end
			if (req_valid && !req_stall)
				owed_replies.push_back(serve(req));
			outstanding <= owed_replies.size();
			mismatches  <= mismatches + fresh;
		end
	end

endmodule

>>> verif/linear_scan_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// Linear scan priority queue testbench
// Drives a directed opening (empty extract, extreme fields, ties, a full
// store and its rejection) and then bursts of random inserts and extracts
// whose mix moves the queue between empty and full. Both channels idle at
// random; the response side also holds off for long stretches so that the
// queue backs up. The checker beside the queue reports the failures.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue_tb;
	import lspq_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	bit steady_sender = 1'b0;

	always #10 clk = ~clk;

	linear_scan_priority_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	linear_scan_priority_queue_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic req_t mk_req(input cmd_t c, input logic [7:0] p, input logic [15:0] w);
		req_t r;
		r.cmd          = c;
		r.priority_req = p;
		r.payload      = w;
		return r;
	endfunction

	function automatic req_t random_request(input int insert_pct, input int prio_mode);
		req_t r;
		r.cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
		case (prio_mode)
			0: r.priority_req = 8'($urandom_range(0, 255));
			1: r.priority_req = 8'($urandom_range(0, 3));
			2: r.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: r.priority_req = 8'hF0 | 8'($urandom_range(0, 15));
		endcase
		r.payload = 16'($urandom_range(0, 16'hFFFF));
		return r;
	endfunction

	task automatic offer(input req_t item);
		int gap;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (steady_sender)
			gap = 0;
		else if ($urandom_range(0, 9) < 6)
			gap = 0;
		else if ($urandom_range(0, 3) != 0)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		int issued;
		int burst;
		int insert_pct;
		int prio_mode;
		bit drained_mid;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(mk_req(CMD_EXTRACT, 8'hFF, 16'hFFFF));
		offer(mk_req(CMD_INSERT, 8'h00, 16'h0000));
		offer(mk_req(CMD_INSERT, 8'hFF, 16'hFFFF));
		offer(mk_req(CMD_INSERT, 8'hFF, 16'h1234));
		offer(mk_req(CMD_INSERT, 8'h07, 16'hA5A5));
		offer(mk_req(CMD_INSERT, 8'h07, 16'h5A5A));
		for (int k = 0; k < DEPTH_DEF - 5; k++)
			offer(mk_req(CMD_INSERT, 8'(k * 23), 16'(k * 4099)));
		offer(mk_req(CMD_INSERT, 8'hC8, 16'h0001));
		repeat (5) offer(mk_req(CMD_EXTRACT, 8'h00, 16'h0000));
		drain();

		issued      = 0;
		drained_mid = 1'b0;
		while (issued < 1400) begin
			burst = $urandom_range(20, 60);
			case ($urandom_range(0, 3))
				0: insert_pct = 25;
				1: insert_pct = 50;
				2: insert_pct = 60;
				default: insert_pct = 85;
			endcase
			prio_mode     = $urandom_range(0, 3);
			steady_sender = ($urandom_range(0, 3) == 0);
			repeat (burst) begin
				offer(random_request(insert_pct, prio_mode));
				issued++;
			end
			if (!drained_mid && issued >= 700) begin
				drained_mid = 1'b1;
				drain();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : receiver
		int served;
		int quiet_left;
		int open_left;
		served     = 0;
		quiet_left = 0;
		open_left  = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				served++;
				if (served == 200 || served == 1000) begin
					quiet_left = LONG_HOLD;
					open_left  = 0;
				end
			end
			if (quiet_left == 0 && open_left == 0) begin
				if ($urandom_range(0, 3) == 0)
					quiet_left = ($urandom_range(0, 9) == 0) ?
						$urandom_range(10, 60) : $urandom_range(1, 3);
				else
					open_left = $urandom_range(1, 30);
			end
			if (quiet_left > 0) begin
				rsp_stall <= 1'b1;
				quiet_left--;
			end else begin
				rsp_stall <= 1'b0;
				open_left--;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> linear_scan_priority_queue.f
rtl/core/lspq_pkg.sv
rtl/core/lspq_ram.sv
rtl/core/linear_scan_priority_queue.sv
verif/linear_scan_priority_queue_checker.sv
verif/linear_scan_priority_queue_tb.sv
